@@ rtl/clock_divider_pair_search_defines.svh @@
// Assertion macros shared by the clock divider pair search RTL.
`ifndef CLOCK_DIVIDER_PAIR_SEARCH_DEFINES_SVH
`define CLOCK_DIVIDER_PAIR_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CDPS_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("clock_divider_pair_search: same-cycle check failed");
`define CDPS_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("clock_divider_pair_search: next-cycle check failed");
`else
`define CDPS_ASSERT_IMP(name, ck, rn, ante, cons)
`define CDPS_ASSERT_NXT(name, ck, rn, ante, cons)
`endif

`endif

@@ rtl/cdps_pkg.sv @@
// Shared constants, types and control structs for the clock divider pair search.
`default_nettype none
package cdps_pkg;

    localparam int unsigned REF_W  = 28;
    localparam int unsigned REQ_W  = 21;
    localparam int unsigned TGT_W  = 25;
    localparam int unsigned M_W    = 8;
    localparam int unsigned D_W    = 6;
    localparam int unsigned ACH_W  = 25;
    localparam int unsigned DIVD_W = 31;
    localparam int unsigned SH_W   = 32;
    localparam int unsigned CNT_W  = 5;
    localparam int unsigned PROD_W = 14;
    localparam int unsigned ERR_W  = 28;
    localparam int unsigned LO_W   = 39;
    localparam int unsigned HI_W   = 32;

    localparam logic [D_W-1:0]   MAX_BIT_DIVIDER = D_W'(63);
    localparam logic [D_W-1:0]   BIT_MIN         = D_W'(3);
    localparam logic [M_W-1:0]   MASTER_MAX      = M_W'(255);
    localparam logic [M_W-1:0]   MASTER_MIN      = M_W'(2);
    localparam logic [REF_W-1:0] REF_RESET       = REF_W'(90000000);

    // Number of quotient bits produced by each division.
    localparam logic [CNT_W-1:0] STEPS_MASTER = CNT_W'(M_W);
    localparam logic [CNT_W-1:0] STEPS_REF    = CNT_W'(REF_W);

    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] steps;
    } div_req_t;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_MUL      = 12'b0000_0000_0010,
        ST_CHK_LO   = 12'b0000_0000_0100,
        ST_CHK_HI   = 12'b0000_0000_1000,
        ST_DIV_M    = 12'b0000_0001_0000,
        ST_MUL_FR   = 12'b0000_0010_0000,
        ST_DIV_FR   = 12'b0000_0100_0000,
        ST_CMP      = 12'b0000_1000_0000,
        ST_NEXT     = 12'b0001_0000_0000,
        ST_FIN_PROD = 12'b0010_0000_0000,
        ST_FIN_DIV  = 12'b0100_0000_0000,
        ST_WAIT_ACH = 12'b1000_0000_0000
    } state_t;

endpackage
`default_nettype wire

@@ rtl/cdps_serial_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
`include "clock_divider_pair_search_defines.svh"
module cdps_serial_div
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire cdps_pkg::div_req_t            req,
    input  wire logic [cdps_pkg::DIVD_W-1:0]   rem_init,
    input  wire logic [cdps_pkg::SH_W-1:0]     num_bits,
    input  wire logic [cdps_pkg::DIVD_W-1:0]   divisor,
    output logic                               done,
    output logic [cdps_pkg::SH_W-1:0]          quotient
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [cdps_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [cdps_pkg::DIVD_W-1:0]   rem_reg, rem_next;
    logic [cdps_pkg::SH_W-1:0]     sh_reg, sh_next;
    logic [cdps_pkg::DIVD_W-1:0]   dvs_reg, dvs_next;
    logic [cdps_pkg::SH_W-1:0]     trial;
    logic [cdps_pkg::SH_W-1:0]     diff;
    logic                          fits;

    // The remainder stays below the divisor, so the trial value fits in one more bit.
    assign trial = {rem_reg, sh_reg[cdps_pkg::SH_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dvs_next  = dvs_reg;
        if (req.load)
        begin
            run_next = 1'b1;
            cnt_next = req.steps;
            rem_next = rem_init;
            sh_next  = num_bits;
            dvs_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[cdps_pkg::DIVD_W-1:0] : trial[cdps_pkg::DIVD_W-1:0];
            sh_next  = {sh_reg[cdps_pkg::SH_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == cdps_pkg::CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = sh_reg;

    `CDPS_ASSERT_NXT(a_load_starts_run, clk, rst_n, req.load, run_reg)
    `CDPS_ASSERT_IMP(a_done_ends_run, clk, rst_n, done_reg, !run_reg)
    `CDPS_ASSERT_IMP(a_run_has_steps, clk, rst_n, run_reg, cnt_reg != '0)

endmodule
`default_nettype wire

@@ rtl/clock_divider_pair_search.sv @@
// Top level of the clock divider pair search: sequencer, search state and result registers.
//
// A request is taken at a rising edge where start is high and busy is low; requested_rate
// is sampled then. busy stays high until the search is over. The result appears on
// master_divider, bit_clock_divider and achieved_rate, marked by done for exactly one cycle,
// and is taken at the edge that ends that cycle; nothing can hold it off.
// busy is low in the done cycle, so the next request may start right then.
// The reference frequency is written with cfg_we and cfg_wdata, and the user must write it
// only while the block is idle; the block itself does not enforce this. Bit-clock dividers
// are tried from 63 down to 3, one at a time. A divider that is not eligible is dropped
// after the window checks; an eligible one runs the serial divider twice, once for the
// master divider and once for the frame rate. Finishing runs it once more for the
// achieved rate. The time a request needs is set by how many dividers are eligible; an
// exact match ends it early.
// One request is in flight at a time.
// Reset empties the sequencer, clears done and busy, and loads 90000000 into the
// reference frequency register.
`default_nettype none
`include "clock_divider_pair_search_defines.svh"
module clock_divider_pair_search
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [cdps_pkg::REQ_W-1:0]    requested_rate,
    input  wire logic                          cfg_we,
    input  wire logic [cdps_pkg::REF_W-1:0]    cfg_wdata,
    output logic                               done,
    output logic [cdps_pkg::M_W-1:0]           master_divider,
    output logic [cdps_pkg::D_W-1:0]           bit_clock_divider,
    output logic [cdps_pkg::ACH_W-1:0]         achieved_rate
);

    cdps_pkg::state_t              state_reg, state_next;
    logic                          done_reg, done_next;
    logic [cdps_pkg::REF_W-1:0]    ref_reg, ref_next;
    logic [cdps_pkg::TGT_W-1:0]    target_reg, target_next;
    logic [cdps_pkg::D_W-1:0]      d_reg, d_next;
    logic [cdps_pkg::DIVD_W-1:0]   div_reg, div_next;
    logic [cdps_pkg::M_W-1:0]      m_reg, m_next;
    logic [cdps_pkg::ERR_W-1:0]    fr_reg, fr_next;
    logic [cdps_pkg::M_W-1:0]      best_m_reg, best_m_next;
    logic [cdps_pkg::D_W-1:0]      best_d_reg, best_d_next;
    logic [cdps_pkg::TGT_W-1:0]    best_err_reg, best_err_next;
    logic [cdps_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [cdps_pkg::M_W-1:0]      master_reg, master_next;
    logic [cdps_pkg::D_W-1:0]      bit_reg, bit_next;
    logic [cdps_pkg::ACH_W-1:0]    ach_reg, ach_next;

    cdps_pkg::div_req_t            div_req;
    logic [cdps_pkg::DIVD_W-1:0]   div_rem_init;
    logic [cdps_pkg::SH_W-1:0]     div_num_bits;
    logic [cdps_pkg::DIVD_W-1:0]   div_divisor;
    logic                          div_done;
    logic [cdps_pkg::SH_W-1:0]     div_quotient;

    logic                          lo_ok;
    logic                          hi_ok;
    logic [cdps_pkg::DIVD_W-1:0]   num_m;
    logic [cdps_pkg::ERR_W-1:0]    target_ext;
    logic [cdps_pkg::ERR_W-1:0]    err;
    logic                          result_legal;

    // The window test ref/(255*d) < target < ref/(2*d) is done with products instead of
    // quotients: the first holds when ref < 255*target*d, the second when
    // 2*(target*d) + 2*d <= ref.
    assign lo_ok = cdps_pkg::LO_W'(ref_reg) <
                   (cdps_pkg::LO_W'({div_reg, 8'b0}) - cdps_pkg::LO_W'(div_reg));
    assign hi_ok = (cdps_pkg::HI_W'({div_reg, 1'b0}) + cdps_pkg::HI_W'({d_reg, 1'b0})) <=
                   cdps_pkg::HI_W'(ref_reg);

    // Rounded master divider numerator; inside the window the quotient is at most 255.
    assign num_m = cdps_pkg::DIVD_W'(ref_reg) + cdps_pkg::DIVD_W'(div_reg >> 1);

    assign target_ext = cdps_pkg::ERR_W'(target_reg);
    assign err = (fr_reg > target_ext) ? (fr_reg - target_ext) : (target_ext - fr_reg);

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        ref_next      = ref_reg;
        target_next   = target_reg;
        d_next        = d_reg;
        div_next      = div_reg;
        m_next        = m_reg;
        fr_next       = fr_reg;
        best_m_next   = best_m_reg;
        best_d_next   = best_d_reg;
        best_err_next = best_err_reg;
        prod_next     = prod_reg;
        master_next   = master_reg;
        bit_next      = bit_reg;
        ach_next      = ach_reg;
        div_req       = '0;
        div_rem_init  = '0;
        div_num_bits  = {ref_reg, 4'b0};
        div_divisor   = div_reg;

        if (cfg_we)
        begin
            ref_next = cfg_wdata;
        end

        unique case (state_reg)
            cdps_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    target_next   = cdps_pkg::TGT_W'({requested_rate, 3'b000}) +
                                    cdps_pkg::TGT_W'(requested_rate);
                    best_err_next = cdps_pkg::TGT_W'({requested_rate, 3'b000}) +
                                    cdps_pkg::TGT_W'(requested_rate);
                    d_next        = cdps_pkg::MAX_BIT_DIVIDER;
                    best_m_next   = cdps_pkg::MASTER_MAX;
                    best_d_next   = cdps_pkg::MAX_BIT_DIVIDER;
                    state_next    = cdps_pkg::ST_MUL;
                end
            end
            cdps_pkg::ST_MUL:
            begin
                div_next   = cdps_pkg::DIVD_W'(target_reg) * cdps_pkg::DIVD_W'(d_reg);
                state_next = cdps_pkg::ST_CHK_LO;
            end
            cdps_pkg::ST_CHK_LO:
            begin
                state_next = lo_ok ? cdps_pkg::ST_CHK_HI : cdps_pkg::ST_NEXT;
            end
            cdps_pkg::ST_CHK_HI:
            begin
                if (hi_ok)
                begin
                    div_req.load  = 1'b1;
                    div_req.steps = cdps_pkg::STEPS_MASTER;
                    div_rem_init  = cdps_pkg::DIVD_W'(num_m[cdps_pkg::DIVD_W-1:cdps_pkg::M_W]);
                    div_num_bits  = {num_m[cdps_pkg::M_W-1:0],
                                     (cdps_pkg::SH_W - cdps_pkg::M_W)'(0)};
                    div_divisor   = div_reg;
                    state_next    = cdps_pkg::ST_DIV_M;
                end
                else
                begin
                    state_next = cdps_pkg::ST_NEXT;
                end
            end
            cdps_pkg::ST_DIV_M:
            begin
                if (div_done)
                begin
                    m_next     = div_quotient[cdps_pkg::M_W-1:0];
                    state_next = cdps_pkg::ST_MUL_FR;
                end
            end
            cdps_pkg::ST_MUL_FR:
            begin
                div_req.load  = 1'b1;
                div_req.steps = cdps_pkg::STEPS_REF;
                div_divisor   = cdps_pkg::DIVD_W'(cdps_pkg::PROD_W'(m_reg) *
                                                  cdps_pkg::PROD_W'(d_reg));
                state_next    = cdps_pkg::ST_DIV_FR;
            end
            cdps_pkg::ST_DIV_FR:
            begin
                if (div_done)
                begin
                    fr_next    = div_quotient[cdps_pkg::ERR_W-1:0];
                    state_next = cdps_pkg::ST_CMP;
                end
            end
            cdps_pkg::ST_CMP:
            begin
                // Only a strictly smaller error wins, so ties keep the larger divider.
                if (err < cdps_pkg::ERR_W'(best_err_reg))
                begin
                    best_m_next   = m_reg;
                    best_d_next   = d_reg;
                    best_err_next = err[cdps_pkg::TGT_W-1:0];
                    state_next    = (err == '0) ? cdps_pkg::ST_FIN_PROD : cdps_pkg::ST_NEXT;
                end
                else
                begin
                    state_next = cdps_pkg::ST_NEXT;
                end
            end
            cdps_pkg::ST_NEXT:
            begin
                if (d_reg == cdps_pkg::BIT_MIN)
                begin
                    state_next = cdps_pkg::ST_FIN_PROD;
                end
                else
                begin
                    d_next     = d_reg - 1'b1;
                    state_next = cdps_pkg::ST_MUL;
                end
            end
            cdps_pkg::ST_FIN_PROD:
            begin
                prod_next  = cdps_pkg::PROD_W'(best_m_reg) * cdps_pkg::PROD_W'(best_d_reg);
                state_next = cdps_pkg::ST_FIN_DIV;
            end
            cdps_pkg::ST_FIN_DIV:
            begin
                // Dividing by nine times the product equals the two truncating divisions.
                div_req.load  = 1'b1;
                div_req.steps = cdps_pkg::STEPS_REF;
                div_divisor   = cdps_pkg::DIVD_W'({prod_reg, 3'b000}) +
                                cdps_pkg::DIVD_W'(prod_reg);
                state_next    = cdps_pkg::ST_WAIT_ACH;
            end
            cdps_pkg::ST_WAIT_ACH:
            begin
                if (div_done)
                begin
                    ach_next    = div_quotient[cdps_pkg::ACH_W-1:0];
                    master_next = best_m_reg;
                    bit_next    = best_d_reg;
                    done_next   = 1'b1;
                    state_next  = cdps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cdps_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            ref_reg   <= cdps_pkg::REF_RESET;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ref_reg   <= ref_next;
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg   <= target_next;
        d_reg        <= d_next;
        div_reg      <= div_next;
        m_reg        <= m_next;
        fr_reg       <= fr_next;
        best_m_reg   <= best_m_next;
        best_d_reg   <= best_d_next;
        best_err_reg <= best_err_next;
        prod_reg     <= prod_next;
        master_reg   <= master_next;
        bit_reg      <= bit_next;
        ach_reg      <= ach_next;
    end

    cdps_serial_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .rem_init (div_rem_init),
        .num_bits (div_num_bits),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign busy              = (state_reg != cdps_pkg::ST_IDLE);
    assign done              = done_reg;
    assign master_divider    = master_reg;
    assign bit_clock_divider = bit_reg;
    assign achieved_rate     = ach_reg;

    assign result_legal = (master_divider >= cdps_pkg::MASTER_MIN) &&
                          (bit_clock_divider >= cdps_pkg::BIT_MIN);

    `CDPS_ASSERT_NXT(a_start_sets_busy, clk, rst_n, start && !busy, busy)
    `CDPS_ASSERT_IMP(a_done_when_idle, clk, rst_n, done, !busy)
    `CDPS_ASSERT_IMP(a_result_in_range, clk, rst_n, done, result_legal)
    `CDPS_ASSERT_IMP(a_best_err_bounded, clk, rst_n, busy, best_err_reg <= target_reg)

endmodule
`default_nettype wire
